@@ design/gcr_pkg.sv @@
`timescale 1ns / 1ps
package gcr_pkg;
  localparam int MaxInt = 8;
  localparam int MaxExt = 8;
  localparam int IdxW = 3;
  localparam int LblW = 4;

  typedef logic [LblW-1:0] lbl_t;
  typedef struct packed {
    lbl_t a;
    lbl_t b;
  } pair_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_INIT, ST_SCAN_I, ST_SCAN_J, ST_SWAP, ST_REV,
    ST_BUILD, ST_CMP, ST_OUT
  } state_t;

  localparam logic [1:0] REG_EXT  = 2'd0;
  localparam logic [1:0] REG_INT  = 2'd1;
  localparam logic [1:0] REG_SKIP = 2'd2;
endpackage

@@ design/gcr_cfg.sv @@
`timescale 1ns / 1ps
module gcr_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [3:0]  ext_cnt,
  output logic [3:0]  int_cnt,
  output logic        skip
);
  import gcr_pkg::*;
  logic [3:0] ext_r, int_r;
  logic       skip_r;
  logic [1:0] ridx;

  assign ridx = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= 4'd2;
      int_r <= 4'd2;
      skip_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_EXT:  ext_r <= cfg_pwdata[3:0];
        REG_INT:  int_r <= cfg_pwdata[3:0];
        REG_SKIP: skip_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    cfg_prdata = '0;
    case (ridx)
      REG_EXT:  cfg_prdata = {28'd0, ext_r};
      REG_INT:  cfg_prdata = {28'd0, int_r};
      REG_SKIP: cfg_prdata = {31'd0, skip_r};
      default:  cfg_prdata = '0;
    endcase
  end

  assign ext_cnt = ext_r;
  assign int_cnt = int_r;
  assign skip = skip_r;
endmodule

@@ design/graph_canonical_relabel.sv @@
`timescale 1ns / 1ps
// graph canonical relabeling engine
// in channel: one target pair per request, tdata = {sign_negative, second_target,
//   first_target} (zero filled to 16 bits); the sign is read with the first pair.
// after internal_count pairs the block walks all permutations of the internal
//   labels in lexicographic order, one sequencer step per cycle: each permutation
//   costs a next-permutation step (scan, swap and reversal), a relabel pass and a
//   compare pass, all run by the single shared unit.
// out channel: n requests, tdata = {sign_out, second_out, first_out}, tlast marks
//   the final pair. in_tready is low from the last pair until the final result
//   has been taken; a stalled receiver simply holds the block.
// with skip_canonical set the pairs pass through in load order.
// reset (rst_n, synchronous) clears the load count and the sequencer, and
//   restores register defaults external 2, internal 2, skip 0.
// configuration uses an APB-style port with pready always high; write only
//   while the block is idle.
module graph_canonical_relabel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // first_target[3:0], second_target[7:4], sign_negative[8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // first_out[3:0], second_out[7:4], sign_out[8]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import gcr_pkg::*;

  logic [3:0] ext_cnt, int_cnt;
  logic       skip;

  gcr_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .ext_cnt, .int_cnt, .skip
  );

  state_t st_r, st_nxt;
  pair_t  loaded_r [MaxInt];
  pair_t  best_r   [MaxInt];
  pair_t  cand_r   [MaxInt];
  lbl_t   perm_r   [MaxInt];
  logic [IdxW:0] load_cnt_r;
  logic   sign_r, par_r, cpar_r;
  logic [3:0] n_r, e_r;
  logic [IdxW-1:0] i_r, j_r, k_r;
  logic [IdxW:0] n_eff;
  logic [3:0] e_eff;
  logic   acc, ofire;
  logic   init_par;

  // effective counts
  always_comb begin
    n_eff = (int_cnt == 4'd0) ? 4'd1 : (int_cnt > 4'(MaxInt) ? 4'(MaxInt) : int_cnt);
    e_eff = (ext_cnt > 4'(MaxExt)) ? 4'(MaxExt) : ext_cnt;
  end

  assign acc   = in_tvalid && in_tready;
  assign ofire = out_tvalid && out_tready;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD:   if (acc && (load_cnt_r + 4'd1 >= n_eff))
                   st_nxt = skip ? ST_OUT : ST_INIT;
      ST_INIT:   st_nxt = (n_r < 4'd2) ? ST_OUT : ST_SCAN_I;
      ST_SCAN_I: if (i_r == '0) st_nxt = ST_OUT;
                 else if (perm_r[i_r - 1'b1] < perm_r[i_r]) st_nxt = ST_SCAN_J;
      ST_SCAN_J: if (perm_r[j_r] > perm_r[i_r - 1'b1]) st_nxt = ST_SWAP;
      ST_SWAP:   st_nxt = ST_REV;
      ST_REV:    if (!(i_r < j_r)) st_nxt = ST_BUILD;
      ST_BUILD:  if (4'(k_r) + 4'd1 >= n_r) st_nxt = ST_CMP;
      ST_CMP:    if (4'(k_r) + 4'd1 >= n_r || cand_r[k_r] != best_r[k_r])
                   st_nxt = ST_SCAN_I;
      ST_OUT:    if (ofire && 4'(k_r) + 4'd1 >= n_r) st_nxt = ST_LOAD;
      default:   st_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = (st_r == ST_LOAD);
    out_tvalid = (st_r == ST_OUT);
    out_tlast  = (4'(k_r) + 4'd1 >= n_r);
    out_tdata  = {7'd0, sign_r ^ par_r, best_r[k_r].b, best_r[k_r].a};
  end

  function automatic pair_t sort_p(pair_t p);
    pair_t r;
    r = p;
    if (p.a > p.b) begin
      r.a = p.b;
      r.b = p.a;
    end
    return r;
  endfunction

  function automatic lbl_t rel(lbl_t v, logic [3:0] e, logic [3:0] n, lbl_t pv);
    logic [4:0] tot;
    tot = 5'(e) + 5'(n);
    return (5'(v) < tot && v >= e) ? pv : v;
  endfunction

  // swap parity of the loaded graph
  always_comb begin
    init_par = 1'b0;
    for (int q = 0; q < MaxInt; q++) begin
      if (4'(q) < n_r && loaded_r[q].a > loaded_r[q].b) init_par = ~init_par;
    end
  end

  lbl_t  s_lbl;
  logic [3:0] slot;
  pair_t rp;
  always_comb begin
    s_lbl = perm_r[k_r];
    slot = s_lbl - e_r;
    rp.a = rel(loaded_r[k_r].a, e_r, n_r, perm_r[3'(loaded_r[k_r].a - e_r)]);
    rp.b = rel(loaded_r[k_r].b, e_r, n_r, perm_r[3'(loaded_r[k_r].b - e_r)]);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      load_cnt_r <= '0;
      k_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_LOAD: if (acc) begin
          if (load_cnt_r + 4'd1 >= n_eff) begin
            load_cnt_r <= '0;
            k_r <= '0;
          end else begin
            load_cnt_r <= load_cnt_r + 4'd1;
          end
        end
        ST_SWAP:  k_r <= '0;
        ST_BUILD: k_r <= (4'(k_r) + 4'd1 >= n_r) ? '0 : k_r + 1'b1;
        ST_CMP:   if (st_nxt != ST_CMP) k_r <= '0; else k_r <= k_r + 1'b1;
        ST_SCAN_I: if (i_r == '0) k_r <= '0;
        ST_OUT:   if (ofire) k_r <= k_r + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st_r)
      ST_LOAD: if (acc) begin
        if (load_cnt_r == '0) sign_r <= in_tdata[8];
        loaded_r[load_cnt_r[IdxW-1:0]] <= '{a: in_tdata[3:0], b: in_tdata[7:4]};
        best_r[load_cnt_r[IdxW-1:0]]   <= '{a: in_tdata[3:0], b: in_tdata[7:4]};
        n_r <= n_eff;
        e_r <= e_eff;
        par_r <= 1'b0;
        for (int q = 0; q < MaxInt; q++) perm_r[q] <= 4'(e_eff + 4'(q));
      end
      ST_INIT: begin
        par_r <= init_par;
        for (int q = 0; q < MaxInt; q++) begin
          best_r[q] <= sort_p(loaded_r[q]);
        end
        i_r <= 3'(n_r - 4'd1);
      end
      ST_SCAN_I: begin
        if (i_r == '0) begin
          // last permutation reached
        end else if (perm_r[i_r - 1'b1] < perm_r[i_r]) j_r <= 3'(n_r - 4'd1);
        else i_r <= i_r - 1'b1;
      end
      ST_SCAN_J: if (!(perm_r[j_r] > perm_r[i_r - 1'b1])) j_r <= j_r - 1'b1;
      ST_SWAP: begin
        perm_r[i_r - 1'b1] <= perm_r[j_r];
        perm_r[j_r] <= perm_r[i_r - 1'b1];
        j_r <= 3'(n_r - 4'd1);
        cpar_r <= 1'b0;
      end
      ST_REV: if (i_r < j_r) begin
        perm_r[i_r] <= perm_r[j_r];
        perm_r[j_r] <= perm_r[i_r];
        i_r <= i_r + 1'b1;
        j_r <= j_r - 1'b1;
      end
      ST_BUILD: begin
        cand_r[slot[IdxW-1:0]] <= sort_p(rp);
        if (rp.a > rp.b) cpar_r <= ~cpar_r;
      end
      ST_CMP: begin
        if (cand_r[k_r] != best_r[k_r] || 4'(k_r) + 4'd1 >= n_r) begin
          if (cand_r[k_r] < best_r[k_r]) begin
            best_r <= cand_r;
            par_r <= cpar_r;
          end
          i_r <= 3'(n_r - 4'd1);
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input and output active together");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) load_cnt_r <= 4'(MaxInt))
    else $error("load count overflow");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
      ofire && out_tlast |=> in_tready)
    else $error("not ready after last result");
`endif
endmodule

@@ tb/sv/tb_graph_canonical_relabel.sv @@
`timescale 1ns / 1ps
module tb_graph_canonical_relabel;
  import gcr_pkg::*;

  // one expected result pair
  typedef struct {
    logic [3:0] lo;
    logic [3:0] hi;
    logic       sgn;
    logic       lst;
  } canon_pair_t;

  // relabel predictor and store of expected canonical pairs
  class canon_scoreboard;
    logic [3:0] ext_cfg = 4'd2;
    logic [3:0] int_cfg = 4'd2;
    logic       skip_cfg = 1'b0;
    logic [3:0] ld_a[8], ld_b[8];
    logic [3:0] best_a[8], best_b[8];
    logic [3:0] cand_a[8], cand_b[8];
    logic [3:0] perm[16];
    int         load_cnt = 0;
    logic       held_sgn = 1'b0;
    logic       best_par = 1'b0;
    canon_pair_t expected_pairs[$];
    int         errors = 0;
    int         graphs = 0;
    int         pairs_checked = 0;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == REG_EXT) ext_cfg = val[3:0];
      else if (idx == REG_INT) int_cfg = val[3:0];
      else if (idx == REG_SKIP) skip_cfg = val[0];
    endfunction

    // ascending order of each pair, returns swap parity
    function logic sort_cands(int n);
      logic p;
      logic [3:0] t;
      p = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (cand_a[i] > cand_b[i]) begin
          t = cand_a[i]; cand_a[i] = cand_b[i]; cand_b[i] = t;
          p = ~p;
        end
      end
      return p;
    endfunction

    function bit cands_less(int n);
      for (int i = 0; i < n; i++) begin
        if (cand_a[i] != best_a[i]) return cand_a[i] < best_a[i];
        if (cand_b[i] != best_b[i]) return cand_b[i] < best_b[i];
      end
      return 0;
    endfunction

    // next lexicographic permutation of perm[e .. e+n-1]
    function bit step_perm(int e, int n);
      int i, j;
      logic [3:0] t;
      if (n < 2) return 0;
      i = n - 1;
      while (i > 0 && perm[e+i-1] >= perm[e+i]) i--;
      if (i == 0) return 0;
      j = n - 1;
      while (perm[e+j] <= perm[e+i-1]) j--;
      t = perm[e+i-1]; perm[e+i-1] = perm[e+j]; perm[e+j] = t;
      j = n - 1;
      while (i < j) begin
        t = perm[e+i]; perm[e+i] = perm[e+j]; perm[e+j] = t;
        i++; j--;
      end
      return 1;
    endfunction

    function logic [3:0] map_label(logic [3:0] v, int total);
      return (v < total) ? perm[v] : v;
    endfunction

    function void canonicalize(int e, int n);
      int slot;
      logic p;
      for (int i = 0; i < 8; i++) begin
        cand_a[i] = ld_a[i]; cand_b[i] = ld_b[i];
      end
      best_par = sort_cands(n);
      best_a = cand_a; best_b = cand_b;
      for (int i = 0; i < 16; i++) perm[i] = i[3:0];
      while (step_perm(e, n)) begin
        for (int i = 0; i < n; i++) begin
          slot = perm[e+i] - e;
          if (slot >= 8 || slot < 0) slot = 0;
          cand_a[slot] = map_label(ld_a[i], e + n);
          cand_b[slot] = map_label(ld_b[i], e + n);
        end
        p = sort_cands(n);
        if (cands_less(n)) begin
          best_a = cand_a; best_b = cand_b;
          best_par = p;
        end
      end
    endfunction

    // accepted request on the input channel
    function void note_pair(logic [3:0] a, logic [3:0] b, logic s);
      int n, e, idx;
      canon_pair_t r;
      n = (int_cfg < 1) ? 1 : (int_cfg > 8) ? 8 : int_cfg;
      e = (ext_cfg > 8) ? 8 : ext_cfg;
      idx = (load_cnt > 7) ? 7 : load_cnt;
      if (idx == 0) held_sgn = s;
      ld_a[idx] = a; ld_b[idx] = b;
      if (idx + 1 < n) begin
        load_cnt = idx + 1;
        return;
      end
      load_cnt = 0;
      graphs++;
      if (skip_cfg) begin
        best_a = ld_a; best_b = ld_b;
        best_par = 1'b0;
      end else begin
        canonicalize(e, n);
      end
      for (int k = 0; k < n; k++) begin
        r.lo = best_a[k]; r.hi = best_b[k];
        r.sgn = held_sgn ^ best_par;
        r.lst = (k + 1 == n);
        expected_pairs.insert(expected_pairs.size(), r);
      end
    endfunction

    // accepted request on the output channel
    function void check_pair(logic [15:0] d, logic l);
      canon_pair_t r;
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result data=%h last=%b", $time, d, l);
        errors++;
        return;
      end
      r = expected_pairs.pop_front();
      pairs_checked++;
      if (d[3:0] !== r.lo || d[7:4] !== r.hi || d[8] !== r.sgn || l !== r.lst) begin
        $display("%0t: mismatch expected lo=%h hi=%h sign=%b last=%b, got lo=%h hi=%h sign=%b last=%b",
                 $time, r.lo, r.hi, r.sgn, r.lst, d[3:0], d[7:4], d[8], l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  canon_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int pairs_sent = 0;

  graph_canonical_relabel i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pair(out_tdata, out_tlast);
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic send_pair(logic [3:0] a, logic [3:0] b, logic s);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {7'd0, s, b, a};
    do @(posedge clk); while (!in_tready);
    sb.note_pair(a, b, s);
    pairs_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // drain results, then let the sequencer settle before a register write
  task automatic wait_quiet();
    while (sb.expected_pairs.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_quiet();
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  task automatic set_graph_cfg(int e, int n, int sk);
    write_reg(REG_EXT, 32'(e));
    write_reg(REG_INT, 32'(n));
    write_reg(REG_SKIP, 32'(sk));
  endtask

  // one full graph, labels mostly inside the vertex set
  task automatic send_graph(bit wide);
    int n, tot;
    logic s;
    n = (sb.int_cfg < 1) ? 1 : (sb.int_cfg > 8) ? 8 : sb.int_cfg;
    tot = ((sb.ext_cfg > 8) ? 8 : sb.ext_cfg) + n;
    s = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      if (wide || tot > 16)
        send_pair(4'($urandom_range(15)), 4'($urandom_range(15)), s);
      else
        send_pair(4'($urandom_range(tot - 1)), 4'($urandom_range(tot - 1)), s);
      s = 1'($urandom_range(1));
    end
  endtask

  task automatic random_phase(int idle, int stall, int quota);
    int start, e, n, sk;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start = pairs_sent;
    while (pairs_sent - start < quota) begin
      if ($urandom_range(2) == 0) begin
        sk = ($urandom_range(3) == 0);
        e = ($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(8);
        n = sk ? $urandom_range(15) : $urandom_range(1, 5);
        set_graph_cfg(e, n, sk);
      end
      send_graph($urandom_range(7) == 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = 16'd0;
    out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = 4'd0; cfg_pwdata = 32'd0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: reset settings, extreme labels
    send_pair(4'd0, 4'd0, 1'b0);
    send_pair(4'd15, 4'd15, 1'b1);
    // single internal vertex, no ground vertices, swapped pair
    set_graph_cfg(0, 1, 0);
    send_pair(4'd3, 4'd1, 1'b1);
    // external count above the maximum, labels beyond the vertex set
    set_graph_cfg(15, 3, 0);
    send_pair(4'd15, 4'd9, 1'b1);
    send_pair(4'd8, 4'd0, 1'b0);
    send_pair(4'd12, 4'd10, 1'b1);
    // skip with internal count above the maximum
    set_graph_cfg(2, 15, 1);
    for (int i = 0; i < 8; i++) send_pair(4'(15 - 2 * i), 4'(i), i[0]);
    // skip with internal count zero
    write_reg(REG_INT, 32'd0);
    send_pair(4'd9, 4'd2, 1'b1);
    // count changed while loading keeps the partial load
    set_graph_cfg(1, 5, 0);
    send_pair(4'd5, 4'd1, 1'b1);
    send_pair(4'd2, 4'd4, 1'b0);
    send_pair(4'd3, 4'd3, 1'b0);
    write_reg(REG_INT, 32'd2);
    send_pair(4'd0, 4'd6, 1'b0);
    // one long walk
    set_graph_cfg(0, 7, 0);
    for (int i = 0; i < 7; i++)
      send_pair(4'($urandom_range(6)), 4'($urandom_range(6)), 1'b1);

    // random traffic across idling phases
    random_phase(0, 0, 20);
    random_phase(85, 0, 20);
    random_phase(0, 85, 20);
    random_phase(19, 19, 20);

    wait_quiet();
    repeat (50) @(negedge clk);
    $display("covered %0d graphs, %0d input pairs, %0d result pairs checked",
             sb.graphs, pairs_sent, sb.pairs_checked);
    $display("skip and canonical modes, count extremes and mid-load count change, four idling phases");
    if (sb.errors == 0 && sb.expected_pairs.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
